>>> src/rwls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rwls_pkg;

  // overview table
  localparam int MAX_LEVELS = 16;
  localparam int LVL_AW     = $clog2(MAX_LEVELS);
  localparam int CNT_W      = 5;

  // coordinate format: index = (coord << IDX_SHIFT) * dim / (res * base_dim)
  localparam int COORD_FRAC_BITS = 8;
  localparam int IDX_SHIFT       = 16 - COORD_FRAC_BITS;

  // shared divider
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 48;

  // level code for the base raster
  localparam logic [4:0] LEVEL_BASE = 5'h1F;

  // register indexes
  localparam logic [2:0] CFG_RASTER_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_RASTER_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_X_RESOLUTION  = 3'd2;
  localparam logic [2:0] CFG_Y_RESOLUTION  = 3'd3;
  localparam logic [2:0] CFG_EXTENT_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_MAX_X_SIZE    = 3'd5;
  localparam logic [2:0] CFG_MAX_Y_SIZE    = 3'd6;
  localparam logic [2:0] CFG_LEVEL_COUNT   = 3'd7;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> src/rwls_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rwls_ram #(
  parameter int DW = 32,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/rwls_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module rwls_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rwls_pkg::div_req_t req,
  output rwls_pkg::div_rsp_t      rsp
);

  import rwls_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;

  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_dif;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_NW-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_dif = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_NW-2:0], ge};
        rem_r <= ge ? rem_dif[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

>>> src/raster_window_level_select_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps a requested load window (Q23.8 local units) to a pixel window of the
// base raster, or of the first overview level whose window fits within
// max_x_size by max_y_size; if none fits, it gives the base window with its
// destination size capped and the requested edges. An item with func=1
// writes one overview table entry, with no result. An item with func=0 gives
// one result. Each window tried (base first, then levels 0 up to
// level_count-1, at most 15) costs four index divisions, then a clamp and a
// fit test; an overview level first reads its table entry. A window that
// fits then takes four more divisions for the snapped edges. All divisions
// go through the single shared 64-step restoring divider. Table entries sit
// in a 16x32 synchronous RAM; a level must be written before level_count
// covers it. Table and configuration writes are expected only while idle.
module raster_window_level_select_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request items
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic [3:0]         in_level_index,
  input  wire logic [15:0]        in_level_width,
  input  wire logic [15:0]        in_level_height,
  input  wire logic [30:0]        in_load_min_x,
  input  wire logic [30:0]        in_load_max_x,
  input  wire logic [30:0]        in_load_min_y,
  input  wire logic [30:0]        in_load_max_y,
  // result items
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [4:0]       out_level,
  output logic [15:0]             out_src_x_offset,
  output logic [15:0]             out_src_y_offset,
  output logic [16:0]             out_src_x_size,
  output logic [16:0]             out_src_y_size,
  output logic [15:0]             out_dst_x_size,
  output logic [15:0]             out_dst_y_size,
  output logic signed [31:0]      out_real_min_x,
  output logic signed [31:0]      out_real_max_x,
  output logic signed [31:0]      out_real_min_y,
  output logic signed [31:0]      out_real_max_y,
  // register writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  import rwls_pkg::*;

  typedef struct packed {
    logic [15:0] off;
    logic [16:0] size;
  } axis_t;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREPX = 4'd1;
  localparam logic [3:0] S_PREPY = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_AXIS  = 4'd5;
  localparam logic [3:0] S_FIT   = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_RDW   = 4'd8;
  localparam logic [3:0] S_SMUL  = 4'd9;
  localparam logic [3:0] S_SDIV  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  function automatic logic [15:0] nz16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // clamp both indices of one axis to its top (the low one also at zero) and form offset and size
  function automatic axis_t axis_f(input logic signed [32:0] a,
                                   input logic signed [32:0] b,
                                   input logic [15:0] dim);
    logic signed [33:0] top;
    logic signed [33:0] ac;
    logic signed [33:0] bc;
    logic signed [33:0] sum;
    axis_t r;
    top = $signed({18'd0, dim}) - 34'sd1;
    ac  = {a[32], a};
    bc  = {b[32], b};
    if (ac < 34'sd0) begin
      ac = 34'sd0;
    end else if (ac > top) begin
      ac = top;
    end
    if (bc > top) begin
      bc = top;
    end
    sum    = bc - ac + 34'sd1;
    r.off  = ac[15:0];
    r.size = (bc >= ac) ? sum[16:0] : 17'd0;
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [15:0] raster_width_r, raster_height_r;
  logic [31:0] x_res_r, y_res_r;
  logic [30:0] ext_h_r;
  logic [15:0] max_x_r, max_y_r;
  logic [4:0]  level_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raster_width_r  <= 16'd1;
      raster_height_r <= 16'd1;
      x_res_r         <= 32'd65536;
      y_res_r         <= 32'd65536;
      ext_h_r         <= '0;
      max_x_r         <= 16'd2048;
      max_y_r         <= 16'd2048;
      level_count_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RASTER_WIDTH:  raster_width_r  <= cfg_data[15:0];
        CFG_RASTER_HEIGHT: raster_height_r <= cfg_data[15:0];
        CFG_X_RESOLUTION:  x_res_r         <= cfg_data;
        CFG_Y_RESOLUTION:  y_res_r         <= cfg_data;
        CFG_EXTENT_HEIGHT: ext_h_r         <= cfg_data[30:0];
        CFG_MAX_X_SIZE:    max_x_r         <= cfg_data[15:0];
        CFG_MAX_Y_SIZE:    max_y_r         <= cfg_data[15:0];
        CFG_LEVEL_COUNT:   level_count_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic        flip;
  logic [31:0] ymag;
  logic [15:0] bw, bh;
  logic [4:0]  n_lv;

  assign flip = y_res_r[31];
  assign ymag = flip ? (~y_res_r + 32'd1) : y_res_r;
  assign bw   = nz16(raster_width_r);
  assign bh   = nz16(raster_height_r);
  assign n_lv = (level_count_r > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS) : level_count_r;

  // ---------------- working state ----------------
  logic [3:0]  state_r;
  logic [1:0]  k_r;
  logic [4:0]  lvl_r;
  logic        is_base_r;
  logic        fallback_r;
  logic [15:0] lw_r, lh_r;
  logic [47:0] den_x_r, den_y_r;
  logic signed [31:0] numer_r [4];      // x lo, x hi, y lo, y hi
  logic signed [32:0] idx_r [4];
  logic signed [31:0] real_r [4];
  logic [30:0] load_r [4];
  axis_t       win_x_r, win_y_r, base_x_r, base_y_r;

  logic        in_accept;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // ---------------- table RAM ----------------
  logic        ram_re;
  logic [31:0] ram_rdata;

  assign ram_re = (state_r == S_RD);

  rwls_ram #(
    .DW (32),
    .AW (LVL_AW)
  ) u_ram (
    .clk   (clk),
    .we    (in_accept && in_func),
    .waddr (in_level_index[LVL_AW-1:0]),
    .wdata ({in_level_width, in_level_height}),
    .re    (ram_re),
    .raddr (lvl_r[LVL_AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- shared divider ----------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  rwls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  logic signed [31:0] sel_num;
  logic [30:0]        sel_mag;
  logic               sel_neg;
  logic [15:0]        sel_dim;
  logic [47:0]        sel_den;
  logic [16:0]        cnt_lo_x, cnt_hi_x, cnt_lo_y, cnt_hi_y, sel_cnt;
  logic [47:0]        snap_den;
  logic [31:0]        qsat;
  logic signed [32:0] idx_new;
  logic [63:0]        qround;
  logic [40:0]        mag41;
  logic signed [42:0] flip_v;
  logic signed [31:0] edge_new;

  always_comb begin
    sel_num  = numer_r[k_r];
    sel_neg  = sel_num[31];
    sel_mag  = sel_neg ? 31'(-sel_num) : sel_num[30:0];
    sel_dim  = k_r[1] ? lh_r : lw_r;
    sel_den  = k_r[1] ? den_y_r : den_x_r;
    cnt_lo_x = {1'b0, win_x_r.off};
    cnt_hi_x = {1'b0, win_x_r.off} + win_x_r.size;
    cnt_lo_y = {1'b0, win_y_r.off};
    cnt_hi_y = {1'b0, win_y_r.off} + win_y_r.size;
    case (k_r)
      2'd0:    sel_cnt = cnt_lo_x;
      2'd1:    sel_cnt = cnt_hi_x;
      2'd2:    sel_cnt = flip ? cnt_hi_y : cnt_lo_y;
      default: sel_cnt = flip ? cnt_lo_y : cnt_hi_y;
    endcase
    snap_den = 48'(sel_dim) << IDX_SHIFT;

    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    if (state_r == S_MUL) begin
      div_req.start = 1'b1;
      div_req.num   = (64'(sel_mag) << IDX_SHIFT) * 64'(sel_dim);
      div_req.den   = sel_den;
    end else if (state_r == S_SMUL) begin
      // product wraps at 64 bits
      div_req.start = 1'b1;
      div_req.num   = 64'(sel_den) * 64'(sel_cnt);
      div_req.den   = snap_den;
    end

    // pixel index: saturate to 32 bits, restore sign
    qsat    = (|div_rsp.quo[63:32]) ? 32'hFFFF_FFFF : div_rsp.quo[31:0];
    idx_new = sel_neg ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});

    // snapped edge: round half up, cap magnitude, optional flip, saturate
    qround = div_rsp.quo +
             64'({div_rsp.rem, 1'b0} >= {1'b0, snap_den});
    mag41  = (qround > 64'h100_0000_0000) ? 41'h100_0000_0000 : qround[40:0];
    flip_v = $signed({12'd0, ext_h_r}) - $signed({2'd0, mag41});
    if (k_r[1] && flip) begin
      edge_new = (flip_v < -43'sd2147483648) ? 32'sh8000_0000 : flip_v[31:0];
    end else begin
      edge_new = (mag41 > 41'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag41[31:0]);
    end
  end

  axis_t ax_x, ax_y;
  logic  fits;
  logic [4:0] lvl_nx;

  always_comb begin
    ax_x   = axis_f(idx_r[0], idx_r[1], lw_r);
    ax_y   = axis_f(idx_r[2], idx_r[3], lh_r);
    fits   = (win_x_r.size <= {1'b0, max_x_r}) && (win_y_r.size <= {1'b0, max_y_r});
    lvl_nx = is_base_r ? 5'd0 : (lvl_r + 5'd1);
  end

  // ---------------- result register ----------------
  logic              out_valid_r;
  logic [4:0]        out_level_r;
  logic [15:0]       out_xo_r, out_yo_r, out_dx_r, out_dy_r;
  logic [16:0]       out_xs_r, out_ys_r;
  logic signed [31:0] out_rmin_x_r, out_rmax_x_r, out_rmin_y_r, out_rmax_y_r;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      lvl_r       <= '0;
      is_base_r   <= 1'b1;
      fallback_r  <= 1'b0;
    end else begin
      // S_DONE reloads the result register itself
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept && !in_func) begin
            load_r[0]  <= in_load_min_x;
            load_r[1]  <= in_load_max_x;
            load_r[2]  <= in_load_min_y;
            load_r[3]  <= in_load_max_y;
            numer_r[0] <= $signed({1'b0, in_load_min_x});
            numer_r[1] <= $signed({1'b0, in_load_max_x});
            numer_r[2] <= flip ? $signed({1'b0, ext_h_r}) - $signed({1'b0, in_load_max_y})
                               : $signed({1'b0, in_load_min_y});
            numer_r[3] <= flip ? $signed({1'b0, ext_h_r}) - $signed({1'b0, in_load_min_y})
                               : $signed({1'b0, in_load_max_y});
            fallback_r <= 1'b0;
            state_r    <= S_PREPX;
          end
        end
        S_PREPX: begin
          den_x_r <= x_res_r * bw;
          state_r <= S_PREPY;
        end
        S_PREPY: begin
          den_y_r   <= ymag * bh;
          lw_r      <= bw;
          lh_r      <= bh;
          is_base_r <= 1'b1;
          k_r       <= '0;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            idx_r[k_r] <= idx_new;
            k_r        <= k_r + 2'd1;
            state_r    <= (k_r == 2'd3) ? S_AXIS : S_MUL;
          end
        end
        S_AXIS: begin
          win_x_r <= ax_x;
          win_y_r <= ax_y;
          state_r <= S_FIT;
        end
        S_FIT: begin
          if (fits) begin
            k_r     <= '0;
            state_r <= S_SMUL;
          end else begin
            if (is_base_r) begin
              base_x_r <= win_x_r;
              base_y_r <= win_y_r;
            end
            if (lvl_nx < n_lv) begin
              lvl_r   <= lvl_nx;
              state_r <= S_RD;
            end else begin
              fallback_r <= 1'b1;
              state_r    <= S_DONE;
            end
          end
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          lw_r      <= nz16(ram_rdata[31:16]);
          lh_r      <= nz16(ram_rdata[15:0]);
          is_base_r <= 1'b0;
          k_r       <= '0;
          state_r   <= S_MUL;
        end
        S_SMUL: begin
          state_r <= S_SDIV;
        end
        S_SDIV: begin
          if (div_rsp.done) begin
            real_r[k_r] <= edge_new;
            k_r         <= k_r + 2'd1;
            state_r     <= (k_r == 2'd3) ? S_DONE : S_SMUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (fallback_r) begin
              out_level_r  <= LEVEL_BASE;
              out_xo_r     <= base_x_r.off;
              out_yo_r     <= base_y_r.off;
              out_xs_r     <= base_x_r.size;
              out_ys_r     <= base_y_r.size;
              out_dx_r     <= (base_x_r.size < {1'b0, max_x_r}) ? base_x_r.size[15:0]
                                                                 : max_x_r;
              out_dy_r     <= (base_y_r.size < {1'b0, max_y_r}) ? base_y_r.size[15:0]
                                                                 : max_y_r;
              out_rmin_x_r <= $signed({1'b0, load_r[0]});
              out_rmax_x_r <= $signed({1'b0, load_r[1]});
              out_rmin_y_r <= $signed({1'b0, load_r[2]});
              out_rmax_y_r <= $signed({1'b0, load_r[3]});
            end else begin
              out_level_r  <= is_base_r ? LEVEL_BASE : lvl_r;
              out_xo_r     <= win_x_r.off;
              out_yo_r     <= win_y_r.off;
              out_xs_r     <= win_x_r.size;
              out_ys_r     <= win_y_r.size;
              out_dx_r     <= win_x_r.size[15:0];
              out_dy_r     <= win_y_r.size[15:0];
              out_rmin_x_r <= real_r[0];
              out_rmax_x_r <= real_r[1];
              out_rmin_y_r <= real_r[2];
              out_rmax_y_r <= real_r[3];
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_level        = $signed(out_level_r);
  assign out_src_x_offset = out_xo_r;
  assign out_src_y_offset = out_yo_r;
  assign out_src_x_size   = out_xs_r;
  assign out_src_y_size   = out_ys_r;
  assign out_dst_x_size   = out_dx_r;
  assign out_dst_y_size   = out_dy_r;
  assign out_real_min_x   = out_rmin_x_r;
  assign out_real_max_x   = out_rmax_x_r;
  assign out_real_min_y   = out_rmin_y_r;
  assign out_real_max_y   = out_rmax_y_r;

  // ---------------- checks ----------------
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV || state_r == S_SDIV))
    else $error("divider finished outside a division wait");

  a_table_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (lvl_r < CNT_W'(MAX_LEVELS)))
    else $error("overview read beyond table");

  a_request_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_func) |=> in_stall)
    else $error("window request did not start work");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded on completion");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without completion");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rwls_pkg::*;

  // Clock, reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT ports
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [3:0]  in_level_index = '0;
  logic [15:0] in_level_width = '0;
  logic [15:0] in_level_height = '0;
  logic [30:0] in_load_min_x = '0;
  logic [30:0] in_load_max_x = '0;
  logic [30:0] in_load_min_y = '0;
  logic [30:0] in_load_max_y = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [4:0]  out_level;
  logic [15:0]        out_src_x_offset, out_src_y_offset;
  logic [16:0]        out_src_x_size, out_src_y_size;
  logic [15:0]        out_dst_x_size, out_dst_y_size;
  logic signed [31:0] out_real_min_x, out_real_max_x, out_real_min_y, out_real_max_y;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  raster_window_level_select_core DUT (.*);

  // One request item: a table write (func=1) or a window request (func=0)
  typedef struct {
    bit        func;
    bit [3:0]  idx;
    bit [15:0] lvl_w, lvl_h;
    bit [30:0] min_x, max_x, min_y, max_y;
  } req_t;

  // One window result
  typedef struct {
    bit [4:0]  level;
    bit [15:0] off_x, off_y;
    bit [16:0] size_x, size_y;
    bit [15:0] dst_x, dst_y;
    bit [31:0] rmin_x, rmax_x, rmin_y, rmax_y;
  } win_t;

  req_t pending_reqs[$];
  win_t expected_wins[$];
  int   errors = 0;
  bit   quiet = 1'b0;   // no idling on either side near the end of the run

  function automatic void queue_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void queue_win(win_t w);
    expected_wins = {expected_wins, w};
  endfunction

  // Shadow copy of the registers and the overview table
  bit [15:0] sh_width, sh_height, sh_max_x, sh_max_y;
  bit [31:0] sh_xres, sh_yres;
  bit [30:0] sh_ext;
  bit [4:0]  sh_count;
  bit [15:0] sh_lvl_w[MAX_LEVELS];
  bit [15:0] sh_lvl_h[MAX_LEVELS];

  function automatic bit [63:0] nz(bit [63:0] v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  // trunc((coord << IDX_SHIFT) * lvl_dim / (res * base_dim)), capped at 32 bits
  function automatic longint pix_index(longint coord, bit [63:0] res, bit [63:0] dim_lv,
                                       bit [63:0] dim_base);
    bit        neg;
    bit [63:0] mag, den, q;
    neg = coord < 0;
    mag = neg ? 64'(-coord) : 64'(coord);
    den = res * dim_base;
    q = (den != 0) ? ((mag << IDX_SHIFT) * dim_lv) / den : '1;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void axis_span(longint lo, longint hi, bit [63:0] res, bit [63:0] dim_lv,
                                    bit [63:0] dim_base, output longint off, output longint sz);
    longint top, a, b;
    top = longint'(dim_lv) - 1;
    a = pix_index(lo, res, dim_lv, dim_base);
    b = pix_index(hi, res, dim_lv, dim_base);
    if (a < 0) a = 0;
    if (a > top) a = top;
    if (b > top) b = top;
    off = a;
    sz = (b >= a) ? b - a + 1 : 0;
  endfunction

  function automatic void pixel_window(bit [63:0] lw, bit [63:0] lh, req_t r, bit [63:0] ymag,
                                       bit flip, output longint ox, output longint sx,
                                       output longint oy, output longint sy);
    longint ext;
    ext = longint'(sh_ext);
    axis_span(longint'(r.min_x), longint'(r.max_x), 64'(sh_xres), lw, nz(64'(sh_width)), ox, sx);
    if (flip)
      axis_span(ext - longint'(r.max_y), ext - longint'(r.min_y), ymag, lh,
                nz(64'(sh_height)), oy, sy);
    else
      axis_span(longint'(r.min_y), longint'(r.max_y), ymag, lh, nz(64'(sh_height)), oy, sy);
  endfunction

  // res*base*count / (lvl << IDX_SHIFT), rounded half up (64-bit wrap as specified)
  function automatic bit [63:0] snap_mag(bit [63:0] res, bit [63:0] dim_base, bit [63:0] cnt,
                                         bit [63:0] dim_lv);
    bit [63:0] num, den, q, r;
    num = res * dim_base * cnt;
    den = dim_lv << IDX_SHIFT;
    q = num / den;
    r = num % den;
    if (r >= den - r) q++;
    return q;
  endfunction

  function automatic bit [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic bit [31:0] snap_edge(bit [63:0] mag, bit flip);
    if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
    return flip ? sat32(longint'(sh_ext) - longint'(mag)) : sat32(longint'(mag));
  endfunction

  // Apply one accepted request to the shadow state; queue its result if it has one
  function automatic void predict_window(req_t r);
    bit [63:0] bw, bh, lw, lh, ymag, n;
    bit        flip, fits;
    bit [31:0] yneg;
    longint    ox, sx, oy, sy;
    int        lvl;
    win_t      w;
    if (r.func) begin
      sh_lvl_w[r.idx] = r.lvl_w;
      sh_lvl_h[r.idx] = r.lvl_h;
      return;
    end
    bw = nz(64'(sh_width));
    bh = nz(64'(sh_height));
    lw = bw;
    lh = bh;
    flip = sh_yres[31];
    yneg = ~sh_yres + 32'd1;
    ymag = flip ? 64'(yneg) : 64'(sh_yres);
    lvl = -1;
    pixel_window(bw, bh, r, ymag, flip, ox, sx, oy, sy);
    fits = sx <= longint'(sh_max_x) && sy <= longint'(sh_max_y);
    if (!fits) begin
      n = (sh_count > MAX_LEVELS) ? MAX_LEVELS : sh_count;
      for (int i = 0; i < n; i++) begin
        lw = nz(64'(sh_lvl_w[i]));
        lh = nz(64'(sh_lvl_h[i]));
        pixel_window(lw, lh, r, ymag, flip, ox, sx, oy, sy);
        if (sx <= longint'(sh_max_x) && sy <= longint'(sh_max_y)) begin
          lvl = i;
          break;
        end
      end
      if (lvl < 0) begin
        // nothing fits: base window, capped destination, requested edges
        pixel_window(bw, bh, r, ymag, flip, ox, sx, oy, sy);
        w.level  = LEVEL_BASE;
        w.off_x  = ox[15:0];
        w.off_y  = oy[15:0];
        w.size_x = sx[16:0];
        w.size_y = sy[16:0];
        w.dst_x  = (sx < longint'(sh_max_x)) ? sx[15:0] : sh_max_x;
        w.dst_y  = (sy < longint'(sh_max_y)) ? sy[15:0] : sh_max_y;
        w.rmin_x = 32'(r.min_x);
        w.rmax_x = 32'(r.max_x);
        w.rmin_y = 32'(r.min_y);
        w.rmax_y = 32'(r.max_y);
        queue_win(w);
        return;
      end
    end
    w.level  = 5'(lvl);
    w.off_x  = ox[15:0];
    w.off_y  = oy[15:0];
    w.size_x = sx[16:0];
    w.size_y = sy[16:0];
    w.dst_x  = sx[15:0];
    w.dst_y  = sy[15:0];
    w.rmin_x = snap_edge(snap_mag(64'(sh_xres), bw, 64'(ox), lw), 1'b0);
    w.rmax_x = snap_edge(snap_mag(64'(sh_xres), bw, 64'(ox + sx), lw), 1'b0);
    if (flip) begin
      w.rmin_y = snap_edge(snap_mag(ymag, bh, 64'(oy + sy), lh), 1'b1);
      w.rmax_y = snap_edge(snap_mag(ymag, bh, 64'(oy), lh), 1'b1);
    end else begin
      w.rmin_y = snap_edge(snap_mag(ymag, bh, 64'(oy), lh), 1'b0);
      w.rmax_y = snap_edge(snap_mag(ymag, bh, 64'(oy + sy), lh), 1'b0);
    end
    queue_win(w);
  endfunction

  // Driver: one item in flight on the request channel, random gaps between items
  int   in_gap = 0;
  req_t held;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_window(held);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          held = pending_reqs.pop_front();
          in_func         <= held.func;
          in_level_index  <= held.idx;
          in_level_width  <= held.lvl_w;
          in_level_height <= held.lvl_h;
          in_load_min_x   <= held.min_x;
          in_load_max_x   <= held.max_x;
          in_load_min_y   <= held.min_y;
          in_load_max_y   <= held.max_y;
          in_valid <= 1'b1;
          // gap after this item; some stretches stay gap-free
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: compares results, random stall bursts, one long hold-off
  int out_burst = 0;
  int hold_left = 0;
  int wins_seen = 0;
  bit held_off = 1'b0;

  always @(posedge clk) begin
    win_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        wins_seen++;
        if (expected_wins.size() == 0) begin
          $error("unexpected result item, level %0d", out_level);
          errors++;
        end else begin
          e = expected_wins.pop_front();
          check_field("level", 64'(e.level), 64'(out_level[4:0]));
          check_field("src_x_offset", 64'(e.off_x), 64'(out_src_x_offset));
          check_field("src_y_offset", 64'(e.off_y), 64'(out_src_y_offset));
          check_field("src_x_size", 64'(e.size_x), 64'(out_src_x_size));
          check_field("src_y_size", 64'(e.size_y), 64'(out_src_y_size));
          check_field("dst_x_size", 64'(e.dst_x), 64'(out_dst_x_size));
          check_field("dst_y_size", 64'(e.dst_y), 64'(out_dst_y_size));
          check_field("real_min_x", 64'(e.rmin_x), 64'(out_real_min_x[31:0]));
          check_field("real_max_x", 64'(e.rmax_x), 64'(out_real_max_x[31:0]));
          check_field("real_min_y", 64'(e.rmin_y), 64'(out_real_min_y[31:0]));
          check_field("real_max_y", 64'(e.rmax_y), 64'(out_real_max_y[31:0]));
        end
      end
      // long hold-off once, mid-batch, while the sender keeps offering items
      if (!held_off && wins_seen == 160) begin
        held_off = 1'b1;
        hold_left = 8000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_burst > 0) begin
        out_burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_burst = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles without any handshake
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= 60000) begin
      $display("raster_window_level_select_core regression: fail");
      $finish;
    end
  end

  // Register write; shadow updated at the handshake
  task automatic write_reg(logic [2:0] idx, bit [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RASTER_WIDTH:  sh_width  = val[15:0];
      CFG_RASTER_HEIGHT: sh_height = val[15:0];
      CFG_X_RESOLUTION:  sh_xres   = val;
      CFG_Y_RESOLUTION:  sh_yres   = val;
      CFG_EXTENT_HEIGHT: sh_ext    = val[30:0];
      CFG_MAX_X_SIZE:    sh_max_x  = val[15:0];
      CFG_MAX_Y_SIZE:    sh_max_y  = val[15:0];
      CFG_LEVEL_COUNT:   sh_count  = val[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_wins.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(bit [15:0] w, bit [15:0] h, bit [31:0] xr, bit [31:0] yr,
                            bit [30:0] ext, bit [15:0] mx, bit [15:0] my, bit [4:0] cnt);
    write_reg(CFG_RASTER_WIDTH, 32'(w));
    write_reg(CFG_RASTER_HEIGHT, 32'(h));
    write_reg(CFG_X_RESOLUTION, xr);
    write_reg(CFG_Y_RESOLUTION, yr);
    write_reg(CFG_EXTENT_HEIGHT, 32'(ext));
    write_reg(CFG_MAX_X_SIZE, 32'(mx));
    write_reg(CFG_MAX_Y_SIZE, 32'(my));
    write_reg(CFG_LEVEL_COUNT, 32'(cnt));
  endtask

  // Fill all table entries (halving pyramid with jitter, some random), so no
  // unwritten entry is ever walked; then let the block settle.
  task automatic load_pyramid(bit [15:0] w, bit [15:0] h, bit full_rand);
    req_t r;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      r = '{default: '0};
      r.func  = 1'b1;
      r.idx   = 4'(i);
      r.min_x = 31'($urandom);
      r.max_x = 31'($urandom);
      r.min_y = 31'($urandom);
      r.max_y = 31'($urandom);
      if (full_rand) begin
        r.lvl_w = 16'($urandom_range(1, 65535));
        r.lvl_h = 16'($urandom_range(1, 65535));
      end else begin
        r.lvl_w = 16'((w >> (i + 1)) + $urandom_range(0, 2));
        r.lvl_h = 16'((h >> (i + 1)) + $urandom_range(0, 2));
        if (r.lvl_w == 0) r.lvl_w = 1;
        if (r.lvl_h == 0) r.lvl_h = 1;
      end
      queue_req(r);
    end
    wait_drained();
  endtask

  function automatic req_t window_req(bit [30:0] a, bit [30:0] b, bit [30:0] c, bit [30:0] d);
    req_t r;
    r = '{default: '0};
    r.idx   = 4'($urandom);
    r.lvl_w = 16'($urandom);
    r.lvl_h = 16'($urandom);
    r.min_x = a;
    r.max_x = b;
    r.min_y = c;
    r.max_y = d;
    return r;
  endfunction

  // Random window, mostly inside (or just around) the raster's extent
  function automatic req_t random_window(bit [63:0] span_x, bit [63:0] span_y);
    bit [31:0] lx, ly;
    bit [30:0] a, b, c, d, t;
    lx = (span_x > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : span_x[31:0];
    ly = (span_y > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : span_y[31:0];
    if ($urandom_range(0, 15) == 0) begin
      a = 31'($urandom); b = 31'($urandom); c = 31'($urandom); d = 31'($urandom);
    end else begin
      a = 31'($urandom_range(0, lx)); b = 31'($urandom_range(0, lx));
      c = 31'($urandom_range(0, ly)); d = 31'($urandom_range(0, ly));
      // mostly well ordered, sometimes inverted
      if ($urandom_range(0, 9) != 0) begin
        if (a > b) begin t = a; a = b; b = t; end
        if (c > d) begin t = c; c = d; d = t; end
      end
    end
    return window_req(a, b, c, d);
  endfunction

  initial begin
    bit [15:0] w, h, mx, my;
    bit [31:0] xr, yr;
    bit [30:0] ext;
    bit [63:0] sx, sy;
    bit [4:0]  cnt;
    sh_width = 1; sh_height = 1; sh_xres = 32'd65536; sh_yres = 32'd65536;
    sh_ext = 0; sh_max_x = 2048; sh_max_y = 2048; sh_count = 0;
    foreach (sh_lvl_w[i]) begin
      sh_lvl_w[i] = 0;
      sh_lvl_h[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset values, then field extremes
    queue_req(window_req(0, 0, 0, 0));
    queue_req(window_req('1, '1, '1, '1));
    wait_drained();

    // all registers at their top, flipped rows, count above table depth
    set_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
               16'hFFFF, 16'hFFFF, 5'd31);
    load_pyramid(16'hFFFF, 16'hFFFF, 1'b0);
    queue_req(window_req(0, '1, 0, '1));
    queue_req(window_req('1, 0, '1, 0));        // inverted: zero sizes
    queue_req(window_req(31'h100, 31'h100, 31'h100, 31'h100));
    wait_drained();

    // small limits so the level walk runs and usually falls back
    set_config(16'd1000, 16'd800, 32'd65536, 32'hFFFF_0000, 31'd204800,
               16'd1, 16'd1, 5'd16);
    load_pyramid(16'd1000, 16'd800, 1'b0);
    queue_req(window_req(0, 31'd255999, 0, 31'd204799));
    queue_req(window_req(0, 31'd255, 0, 31'd255));   // single pixel fits
    queue_req(window_req(31'd1000, 31'd300000, 31'd1000, 31'd300000));
    wait_drained();

    // zero raster dimensions act as 1; zero resolutions saturate the indices
    set_config(16'd0, 16'd0, 32'd0, 32'd0, 31'd5000, 16'd10, 16'd10, 5'd2);
    load_pyramid(16'd0, 16'd0, 1'b1);
    queue_req(window_req(0, 31'd1000, 0, 31'd1000));
    queue_req(window_req(31'd5, 31'd6000, 31'd7, 31'd9000));
    wait_drained();

    // registers at their bottom
    set_config(16'd1, 16'd1, 32'd1, 32'd1, 31'd0, 16'd1, 16'd1, 5'd0);
    queue_req(window_req(0, 31'd7, 0, 31'd7));
    queue_req(window_req('1, '1, 0, 0));
    wait_drained();

    // Random phases: new registers and pyramid, then a batch of windows
    for (int ph = 0; ph < 30; ph++) begin
      w  = $urandom_range(1, 4) == 1 ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(2, 3000));
      h  = $urandom_range(1, 4) == 1 ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(2, 3000));
      xr = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(256, 1 << 20));
      yr = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(256, 1 << 20));
      if ($urandom_range(0, 1)) yr = ~yr + 32'd1;
      if (yr == 0) yr = 32'd65536;
      sx = (64'(xr) * 64'(w)) >> 8;
      sy = (64'(yr[31] ? ~yr + 32'd1 : yr) * 64'(h)) >> 8;
      sx = sx + (sx >> 3) + 1;
      sy = sy + (sy >> 3) + 1;
      ext = (sy > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sy[30:0];
      if ($urandom_range(0, 3) == 0) ext = 31'($urandom);
      mx  = 16'($urandom_range(1, w));
      my  = 16'($urandom_range(1, h));
      // mostly few levels, so the walk stays short
      cnt = $urandom_range(0, 5) == 0 ? 5'($urandom_range(6, 31)) : 5'($urandom_range(0, 5));
      set_config(w, h, xr, yr, ext, mx, my, cnt);
      load_pyramid(w, h, $urandom_range(0, 5) == 0);
      if (ph == 29) quiet = 1'b1;
      for (int k = 0; k < 35; k++) queue_req(random_window(sx, sy));
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("raster_window_level_select_core regression: pass");
    end else begin
      $display("raster_window_level_select_core regression: fail");
    end
    $finish;
  end

endmodule

>>> raster_window_level_select_core.f
src/rwls_pkg.sv
src/rwls_ram.sv
src/rwls_div.sv
src/raster_window_level_select_core.sv
verif/tb_top.sv
